### hw/rtl/adam_pkg.sv
// Shared constants for the Adam update block: store geometry, divider and
// square-root pipeline geometry, register map codes and reset values.
// No dependencies.
package adam_pkg;

    localparam int MOMENT_DEPTH = 4096;
    localparam int MOM_AW       = $clog2(MOMENT_DEPTH);

    // pipelined divider: 56-bit dividend, 29-bit divisor, 33 quotient bits
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 29;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_LAT   = DIV_Q_W + 1;

    // pipelined square root of a 32-bit value shifted up by 24 bits
    localparam int SQRT_W   = 28;
    localparam int SQRT_LAT = SQRT_W + 1;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    localparam logic [1:0] REG_BETA_ONE   = 2'd0;
    localparam logic [1:0] REG_BETA_TWO   = 2'd1;
    localparam logic [1:0] REG_STABILIZER = 2'd2;
    localparam logic [1:0] REG_STEP_RATE  = 2'd3;

    localparam logic [15:0] BETA_ONE_RST   = 16'd58982;
    localparam logic [15:0] BETA_TWO_RST   = 16'd65470;
    localparam logic [23:0] STABILIZER_RST = 24'd1;
    localparam logic [23:0] STEP_RATE_RST  = 24'd16777;

endpackage

### hw/rtl/adam_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit. Depends on adam_pkg.
module adam_div
    import adam_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_Q_W-1:0]   quo,
    output logic                 ovf
);

    logic [DIV_DEN_W-1:0] rem_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0]   low_reg [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_reg   [DIV_LAT];
    logic                 ovf_reg [DIV_LAT];

    logic [DIV_DEN_W-1:0] rem_next [DIV_Q_W];
    logic                 bit_next [DIV_Q_W];

    always_comb
    begin
        logic [DIV_DEN_W:0] trial;
        for (int k = 0; k < DIV_Q_W; k++)
        begin
            trial = {rem_reg[k], low_reg[k][DIV_Q_W-1]};
            if (trial >= {1'b0, den_reg[k]})
            begin
                rem_next[k] = DIV_DEN_W'(trial - {1'b0, den_reg[k]});
                bit_next[k] = 1'b1;
            end
            else
            begin
                rem_next[k] = trial[DIV_DEN_W-1:0];
                bit_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            low_reg[0] <= num[DIV_Q_W-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= {{(DIV_Q_W + DIV_DEN_W - DIV_NUM_W){1'b0}}, num}
                          >= {den, {DIV_Q_W{1'b0}}};
            for (int k = 0; k < DIV_Q_W; k++)
            begin
                if (k < DIV_Q_W - 1)
                begin
                    rem_reg[k+1] <= rem_next[k];
                    low_reg[k+1] <= {low_reg[k][DIV_Q_W-2:0], 1'b0};
                    den_reg[k+1] <= den_reg[k];
                end
                q_reg[k+1]   <= {q_reg[k][DIV_Q_W-2:0], bit_next[k]};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = q_reg[DIV_Q_W];
    assign ovf = ovf_reg[DIV_Q_W];

endmodule

### hw/rtl/adam_sqrt.sv
// Pipelined integer square root of (val * 2^24), one root bit per stage.
// Depends on adam_pkg.
module adam_sqrt
    import adam_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       val,
    output logic [SQRT_W-1:0] root
);

    localparam int RW = SQRT_W + 2;
    localparam int XW = 2 * SQRT_W;

    logic [XW-1:0]     x_reg    [SQRT_W];
    logic [RW-1:0]     rem_reg  [SQRT_W];
    logic [SQRT_W-1:0] root_reg [SQRT_LAT];

    logic [RW-1:0]     rem_next  [SQRT_W];
    logic [SQRT_W-1:0] root_next [SQRT_W];

    always_comb
    begin
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        for (int k = 0; k < SQRT_W; k++)
        begin
            cur   = {rem_reg[k], x_reg[k][XW-1:XW-2]};
            trial = (RW+2)'({root_reg[k], 2'b01});
            if (cur >= trial)
            begin
                rem_next[k]  = RW'(cur - trial);
                root_next[k] = {root_reg[k][SQRT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = cur[RW-1:0];
                root_next[k] = {root_reg[k][SQRT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= {val, 24'b0};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int k = 0; k < SQRT_W; k++)
            begin
                if (k < SQRT_W - 1)
                begin
                    x_reg[k+1]   <= {x_reg[k][XW-3:0], 2'b00};
                    rem_reg[k+1] <= rem_next[k];
                end
                root_reg[k+1] <= root_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_W];

endmodule

### hw/rtl/adam_optimizer_update.sv
// Adam optimizer element update: top level with moment stores, register
// port and the full update pipeline. Depends on adam_pkg, adam_div, adam_sqrt.
//
// Usage:
//   Requests enter on in_valid/in_ready, one parameter element each, with
//   its store index, weight, gradient and tensor_start flag. tensor_start
//   advances both beta powers before that element is processed.
//   Results leave on out_valid/out_ready: the updated weight and the echoed
//   index, in request order, one per request.
//   Throughput: one request per cycle while the output is not stalled. On its
//   way to the output register a result crosses a 33-step divider pipeline,
//   a 28-step square-root pipeline and a second 33-step divider pipeline.
//   Back-to-back requests to the same index are forwarded around the store
//   read/write gap, so no bubbles are needed.
//   Reset: registers return to their defaults, both beta powers to 1.0 and
//   a clearing pass zeroes both 4096-entry moment stores, one entry per
//   cycle; in_ready stays low until the pass ends. Register writes are
//   taken at any time but are meant for an idle block.
//   Stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
module adam_optimizer_update
    import adam_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        element_index,
    input  logic signed [31:0] weight_in,
    input  logic signed [31:0] gradient,
    input  logic               tensor_start,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] weight_out,
    output logic [11:0]        index_out
);

    // sideband that rides along the first divider pair
    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] w;
        logic [31:0] m;
        logic [31:0] v;
        logic        m_byp;
        logic        v_byp;
        logic        m_neg;
    } div_side_t;

    // sideband along the square root
    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] w;
        logic [31:0] m_hat;
    } sqrt_side_t;

    // sideband along the step divider
    typedef struct packed {
        logic [11:0] idx;
        logic [31:0] w;
        logic        neg;
    } step_side_t;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [15:0] beta_one_reg;
    logic [15:0] beta_two_reg;
    logic [23:0] stabilizer_reg;
    logic [23:0] step_rate_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_one_reg   <= BETA_ONE_RST;
            beta_two_reg   <= BETA_TWO_RST;
            stabilizer_reg <= STABILIZER_RST;
            step_rate_reg  <= STEP_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_BETA_ONE:   beta_one_reg   <= pwdata[15:0];
                REG_BETA_TWO:   beta_two_reg   <= pwdata[15:0];
                REG_STABILIZER: stabilizer_reg <= pwdata[23:0];
                REG_STEP_RATE:  step_rate_reg  <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BETA_ONE:   prdata = {16'b0, beta_one_reg};
            REG_BETA_TWO:   prdata = {16'b0, beta_two_reg};
            REG_STABILIZER: prdata = {8'b0, stabilizer_reg};
            REG_STEP_RATE:  prdata = {8'b0, step_rate_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: one global advance; the output register is last stage
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic en;
    logic clr_reg;
    logic [MOM_AW-1:0] clr_cnt_reg;
    logic in_fire;

    assign en       = ~out_valid_reg | out_ready;
    assign in_ready = en & ~clr_reg;
    assign in_fire  = in_valid & in_ready;

    // clearing pass over both stores after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
                clr_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Beta powers: advance on a tensor start, before the element uses them
    // ------------------------------------------------------------------
    logic [24:0] pw1_reg;
    logic [24:0] pw2_reg;
    logic [24:0] pw1_next;
    logic [24:0] pw2_next;
    logic [40:0] pw1_mul;
    logic [40:0] pw2_mul;

    assign pw1_mul  = pw1_reg * beta_one_reg;
    assign pw2_mul  = pw2_reg * beta_two_reg;
    assign pw1_next = (in_fire & tensor_start) ? pw1_mul[40:16] : pw1_reg;
    assign pw2_next = (in_fire & tensor_start) ? pw2_mul[40:16] : pw2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw1_reg <= ONE_Q24;
            pw2_reg <= ONE_Q24;
        end
        else
        begin
            pw1_reg <= pw1_next;
            pw2_reg <= pw2_next;
        end
    end

    // ------------------------------------------------------------------
    // Moment stores
    // ------------------------------------------------------------------
    logic [31:0] mem_m [MOMENT_DEPTH];
    logic [31:0] mem_v [MOMENT_DEPTH];
    logic [31:0] rdm_reg;
    logic [31:0] rdv_reg;
    logic              mem_we;
    logic [MOM_AW-1:0] mem_wa;
    logic [31:0]       mem_wd_m;
    logic [31:0]       mem_wd_v;

    logic        s2_valid_reg;
    logic [11:0] s2_idx_reg;
    logic [31:0] m_new;
    logic [31:0] v_new;

    assign mem_we   = clr_reg | (en & s2_valid_reg);
    assign mem_wa   = clr_reg ? clr_cnt_reg : s2_idx_reg[MOM_AW-1:0];
    assign mem_wd_m = clr_reg ? 32'b0 : m_new;
    assign mem_wd_v = clr_reg ? 32'b0 : v_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_m[mem_wa] <= mem_wd_m;
            mem_v[mem_wa] <= mem_wd_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdm_reg <= mem_m[element_index[MOM_AW-1:0]];
            rdv_reg <= mem_v[element_index[MOM_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: store read in flight, gradient square
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [11:0] s1_idx_reg;
    logic [31:0] s1_w_reg;
    logic [31:0] s1_g_reg;
    logic [24:0] s1_d1_reg;
    logic [24:0] s1_d2_reg;
    logic        fwd_hit_reg;
    logic [31:0] fwd_m_reg;
    logic [31:0] fwd_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_fire;
            // the item leaving stage 2 writes at this same edge: catch it
            fwd_hit_reg  <= s2_valid_reg
                            & (s2_idx_reg[MOM_AW-1:0] == element_index[MOM_AW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg <= element_index;
            s1_w_reg   <= weight_in;
            s1_g_reg   <= gradient;
            s1_d1_reg  <= ONE_Q24 - pw1_next;
            s1_d2_reg  <= ONE_Q24 - pw2_next;
            fwd_m_reg  <= m_new;
            fwd_v_reg  <= v_new;
        end
    end

    logic [31:0] g_abs;
    logic [63:0] g_sq;
    logic [31:0] sq;
    logic        s1_same;
    logic [31:0] m_old;
    logic [31:0] v_old;

    assign g_abs   = s1_g_reg[31] ? (~s1_g_reg + 32'd1) : s1_g_reg;
    assign g_sq    = g_abs * g_abs;
    assign sq      = (|g_sq[63:56]) ? 32'hFFFF_FFFF : g_sq[55:24];
    assign s1_same = s2_valid_reg
                     & (s2_idx_reg[MOM_AW-1:0] == s1_idx_reg[MOM_AW-1:0]);
    // newest value wins: stage 2 result, then the captured write, then store
    assign m_old   = s1_same ? m_new : (fwd_hit_reg ? fwd_m_reg : rdm_reg);
    assign v_old   = s1_same ? v_new : (fwd_hit_reg ? fwd_v_reg : rdv_reg);

    // ------------------------------------------------------------------
    // Stage 2: moment update, m + (1-b)(g-m) form, written back here
    // ------------------------------------------------------------------
    logic [31:0] s2_w_reg;
    logic [31:0] s2_g_reg;
    logic [31:0] s2_sq_reg;
    logic [31:0] s2_m_reg;
    logic [31:0] s2_v_reg;
    logic [24:0] s2_d1_reg;
    logic [24:0] s2_d2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_idx_reg <= s1_idx_reg;
            s2_w_reg   <= s1_w_reg;
            s2_g_reg   <= s1_g_reg;
            s2_sq_reg  <= sq;
            s2_m_reg   <= m_old;
            s2_v_reg   <= v_old;
            s2_d1_reg  <= s1_d1_reg;
            s2_d2_reg  <= s1_d2_reg;
        end
    end

    logic signed [17:0] c1;
    logic signed [17:0] c2;
    logic signed [32:0] m_diff;
    logic signed [32:0] v_diff;
    logic signed [50:0] m_prod;
    logic signed [50:0] v_prod;
    logic [34:0]        m_sum;
    logic [34:0]        v_sum;

    assign c1     = $signed(18'h10000 - {2'b0, beta_one_reg});
    assign c2     = $signed(18'h10000 - {2'b0, beta_two_reg});
    assign m_diff = $signed({s2_g_reg[31], s2_g_reg}) - $signed({s2_m_reg[31], s2_m_reg});
    assign v_diff = $signed({1'b0, s2_sq_reg}) - $signed({1'b0, s2_v_reg});
    assign m_prod = m_diff * c1;
    assign v_prod = v_diff * c2;
    // a convex mix of two in-range values: no saturation needed
    assign m_sum  = {{3{s2_m_reg[31]}}, s2_m_reg} + m_prod[50:16];
    assign v_sum  = {3'b0, s2_v_reg} + v_prod[50:16];
    assign m_new  = m_sum[31:0];
    assign v_new  = v_sum[31:0];

    // ------------------------------------------------------------------
    // Stage 3: bias-correction divider inputs
    // ------------------------------------------------------------------
    logic        s3_valid_reg;
    logic [11:0] s3_idx_reg;
    logic [31:0] s3_w_reg;
    logic [31:0] s3_m_reg;
    logic [31:0] s3_v_reg;
    logic [24:0] s3_d1_reg;
    logic [24:0] s3_d2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_idx_reg <= s2_idx_reg;
            s3_w_reg   <= s2_w_reg;
            s3_m_reg   <= m_new;
            s3_v_reg   <= v_new;
            s3_d1_reg  <= s2_d1_reg;
            s3_d2_reg  <= s2_d2_reg;
        end
    end

    logic [31:0]          m_abs;
    logic [DIV_NUM_W-1:0] num_m;
    logic [DIV_NUM_W-1:0] num_v;
    logic [DIV_DEN_W-1:0] den_m;
    logic [DIV_DEN_W-1:0] den_v;
    div_side_t            side1_in;

    assign m_abs = s3_m_reg[31] ? (~s3_m_reg + 32'd1) : s3_m_reg;
    assign num_m = {m_abs, 24'b0};
    assign num_v = {s3_v_reg, 24'b0};
    assign den_m = (s3_d1_reg == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(s3_d1_reg);
    assign den_v = (s3_d2_reg == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(s3_d2_reg);

    assign side1_in.idx   = s3_idx_reg;
    assign side1_in.w     = s3_w_reg;
    assign side1_in.m     = s3_m_reg;
    assign side1_in.v     = s3_v_reg;
    assign side1_in.m_byp = (s3_d1_reg == '0);
    assign side1_in.v_byp = (s3_d2_reg == '0);
    assign side1_in.m_neg = s3_m_reg[31];

    logic [DIV_Q_W-1:0] q_m;
    logic [DIV_Q_W-1:0] q_v;
    logic               ovf_m;
    logic               ovf_v;

    adam_div u_div_m (
        .clk (clk),
        .en  (en),
        .num (num_m),
        .den (den_m),
        .quo (q_m),
        .ovf (ovf_m)
    );

    adam_div u_div_v (
        .clk (clk),
        .en  (en),
        .num (num_v),
        .den (den_v),
        .quo (q_v),
        .ovf (ovf_v)
    );

    div_side_t side1_reg [DIV_LAT];
    logic      vld1_reg  [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                vld1_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg[0] <= s3_valid_reg;
            for (int k = 1; k < DIV_LAT; k++)
                vld1_reg[k] <= vld1_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg[0] <= side1_in;
            for (int k = 1; k < DIV_LAT; k++)
                side1_reg[k] <= side1_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Corrected moments: sign, saturation, skip when no step taken yet
    // ------------------------------------------------------------------
    div_side_t  sd1;
    logic [31:0] m_hat;
    logic [31:0] v_hat;

    assign sd1 = side1_reg[DIV_LAT-1];

    always_comb
    begin
        if (sd1.m_byp)
            m_hat = sd1.m;
        else if (sd1.m_neg)
            m_hat = (ovf_m | (q_m > 33'h0_8000_0000)) ? 32'h8000_0000
                                                      : (~q_m[31:0] + 32'd1);
        else
            m_hat = (ovf_m | (q_m > 33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q_m[31:0];

        if (sd1.v_byp)
            v_hat = sd1.v;
        else
            v_hat = (ovf_v | q_v[32]) ? 32'hFFFF_FFFF : q_v[31:0];
    end

    logic [SQRT_W-1:0] root;

    adam_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .val  (v_hat),
        .root (root)
    );

    sqrt_side_t side2_in;
    sqrt_side_t side2_reg [SQRT_LAT];
    logic       vld2_reg  [SQRT_LAT];

    assign side2_in.idx   = sd1.idx;
    assign side2_in.w     = sd1.w;
    assign side2_in.m_hat = m_hat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQRT_LAT; k++)
                vld2_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg[0] <= vld1_reg[DIV_LAT-1];
            for (int k = 1; k < SQRT_LAT; k++)
                vld2_reg[k] <= vld2_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg[0] <= side2_in;
            for (int k = 1; k < SQRT_LAT; k++)
                side2_reg[k] <= side2_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Step operands: rate times |m_hat|, root plus epsilon
    // ------------------------------------------------------------------
    sqrt_side_t sd2;
    logic [31:0] mh_abs;
    logic [DIV_DEN_W-1:0] den_sum;

    assign sd2     = side2_reg[SQRT_LAT-1];
    assign mh_abs  = sd2.m_hat[31] ? (~sd2.m_hat + 32'd1) : sd2.m_hat;
    assign den_sum = DIV_DEN_W'(root) + DIV_DEN_W'(stabilizer_reg);

    logic                 p_valid_reg;
    logic [DIV_NUM_W-1:0] p_prod_reg;
    logic [DIV_DEN_W-1:0] p_den_reg;
    step_side_t           p_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= vld2_reg[SQRT_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_prod_reg     <= step_rate_reg * mh_abs;
            p_den_reg      <= (den_sum == '0) ? DIV_DEN_W'(1) : den_sum;
            p_side_reg.idx <= sd2.idx;
            p_side_reg.w   <= sd2.w;
            p_side_reg.neg <= sd2.m_hat[31];
        end
    end

    logic [DIV_Q_W-1:0] q_s;
    logic               ovf_s;

    adam_div u_div_step (
        .clk (clk),
        .en  (en),
        .num (p_prod_reg),
        .den (p_den_reg),
        .quo (q_s),
        .ovf (ovf_s)
    );

    step_side_t side3_reg [DIV_LAT];
    logic       vld3_reg  [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                vld3_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg[0] <= p_valid_reg;
            for (int k = 1; k < DIV_LAT; k++)
                vld3_reg[k] <= vld3_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg[0] <= p_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
                side3_reg[k] <= side3_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Weight update and saturation, then the output register
    // ------------------------------------------------------------------
    step_side_t  sd3;
    logic [34:0] step_val;
    logic [34:0] w_diff;
    logic [31:0] nw;

    assign sd3      = side3_reg[DIV_LAT-1];
    assign step_val = sd3.neg ? (~{2'b0, q_s} + 35'd1) : {2'b0, q_s};
    assign w_diff   = {{3{sd3.w[31]}}, sd3.w} - step_val;

    always_comb
    begin
        if (ovf_s)
            nw = sd3.neg ? 32'h7FFF_FFFF : 32'h8000_0000;
        else if (!w_diff[34] && (|w_diff[33:31]))
            nw = 32'h7FFF_FFFF;
        else if (w_diff[34] && !(&w_diff[33:31]))
            nw = 32'h8000_0000;
        else
            nw = w_diff[31:0];
    end

    logic [31:0] weight_out_reg;
    logic [11:0] index_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld3_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_out_reg <= nw;
            index_out_reg  <= sd3.idx;
        end
    end

    assign out_valid  = out_valid_reg;
    assign weight_out = weight_out_reg;
    assign index_out  = index_out_reg;

`ifndef SYNTHESIS
    // no request may enter while the stores are being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clr_reg |-> !in_ready)
        else $error("request accepted during store clearing");

    // clearing and pipeline writeback never share the write port
    assert property (@(posedge clk) disable iff (!rst_n) clr_reg |-> !s2_valid_reg)
        else $error("moment writeback during store clearing");

    // beta powers never grow past one
    assert property (@(posedge clk) disable iff (!rst_n)
        (pw1_reg <= ONE_Q24) && (pw2_reg <= ONE_Q24))
        else $error("beta power above one");

    // powers move only when a request is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(pw1_reg) && $stable(pw2_reg)))
        else $error("beta power changed without a request");
`endif

endmodule

### sim/adam_optimizer_update_tb.sv
// Testbench for adam_optimizer_update: drives update requests and register writes,
// predicts each updated weight with a fixed-point Adam model and checks every result.
// Depends on adam_pkg and the adam_optimizer_update RTL.
`timescale 1ns / 100ps

module adam_optimizer_update_tb;
    import adam_pkg::*;

    localparam int LATENCY   = 101;
    localparam int CYCLE_CAP = 1500000;

    typedef struct packed {
        logic [11:0] index;
        logic [31:0] weight;
    } update_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [11:0]        element_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
    logic               tensor_start;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] weight_out;
    logic [11:0]        index_out;

    // predictor state, mirrors the block
    logic signed [31:0] mom_one [MOMENT_DEPTH];
    logic [31:0]        mom_two [MOMENT_DEPTH];
    logic [24:0]        pow_one;
    logic [24:0]        pow_two;
    logic [15:0]        b_one;
    logic [15:0]        b_two;
    logic [23:0]        eps;
    logic [23:0]        lrate;

    update_t            pending_updates[$];
    int                 fail_count;
    int                 cycle_count;
    bit                 hold_off;       // long receiver hold requested
    bit                 stall_enable;   // random receiver stalls on/off

    adam_optimizer_update uut (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("adam_optimizer_update verification failed");
            $finish;
        end
    end

    function automatic logic signed [63:0] clamp_word(logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Compute the updated weight for one request and advance the model state.
    function automatic logic [31:0] adam_weight(logic [11:0] idx, logic signed [31:0] w,
                                                logic signed [31:0] g, logic start);
        logic signed [63:0] g64;
        logic signed [63:0] m;
        logic signed [63:0] m_hat;
        logic signed [63:0] den;
        logic signed [63:0] stp;
        logic [63:0]        mag;
        logic [63:0]        sq;
        logic [63:0]        v;
        logic [63:0]        v_hat;
        logic [63:0]        d_one;
        logic [63:0]        d_two;
        if (start)
        begin
            pow_one = 25'((64'(pow_one) * b_one) >> 16);
            pow_two = 25'((64'(pow_two) * b_two) >> 16);
        end
        g64 = g;
        // arithmetic shift of a signed value is a floor division
        m = (64'(signed'({1'b0, b_one})) * mom_one[idx]
             + (64'sd65536 - 64'(signed'({1'b0, b_one}))) * g64) >>> 16;
        m = clamp_word(m);
        mom_one[idx] = m[31:0];
        mag = (g64 < 0) ? -g64 : g64;
        sq  = (mag * mag) >> 24;
        if (sq > 64'hFFFF_FFFF)
            sq = 64'hFFFF_FFFF;
        v = (64'(b_two) * mom_two[idx] + (64'd65536 - b_two) * sq) >> 16;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        mom_two[idx] = v[31:0];
        d_one = 64'(ONE_Q24) - pow_one;
        d_two = 64'(ONE_Q24) - pow_two;
        // no step taken yet: skip the bias correction
        m_hat = (d_one == 0) ? m : clamp_word((m * 64'sd16777216) / signed'(d_one));
        v_hat = (d_two == 0) ? v : (v << 24) / d_two;
        if (v_hat > 64'hFFFF_FFFF)
            v_hat = 64'hFFFF_FFFF;
        den = signed'(int_root(v_hat << 24)) + eps;
        if (den == 0)
            den = 1;
        stp = (64'(signed'({1'b0, lrate})) * m_hat) / den;
        return 32'(clamp_word(64'(w) - stp));
    endfunction

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_updates.size() == 0)
            begin
                $display("%0t: unexpected result idx %0d weight %h", $time, index_out,
                         weight_out);
                fail_count++;
            end
            else
            begin
                want = pending_updates.pop_front();
                if (want.weight !== weight_out)
                begin
                    $display("%0t: weight mismatch exp %h act %h", $time, want.weight,
                             weight_out);
                    fail_count++;
                end
                if (want.index !== index_out)
                begin
                    $display("%0t: index mismatch exp %0d act %0d", $time, want.index,
                             index_out);
                    fail_count++;
                end
            end
        end
    end

    // Drive out_ready at the falling edge: random stalls, or a long hold.
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (stall_enable && $urandom_range(0, 3) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Drop valid for a random number of cycles; a zero gap keeps it high.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (n > 0)
            in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Offer one request and hold it until accepted; predict at acceptance.
    task automatic send_update(logic [11:0] idx, logic [31:0] w, logic [31:0] g,
                               logic start, bit gaps);
        update_t exp_upd;
        if (gaps && $urandom_range(0, 2) == 0)
            idle_gap();
        in_valid      <= 1'b1;
        element_index <= idx;
        weight_in     <= w;
        gradient      <= g;
        tensor_start  <= start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_upd.index  = idx;
        exp_upd.weight = adam_weight(idx, w, g, start);
        pending_updates.push_back(exp_upd);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    // Register write: setup cycle then access cycle; block must be idle.
    task automatic write_reg(logic [1:0] reg_id, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_id)
            REG_BETA_ONE:   b_one = value[15:0];
            REG_BETA_TWO:   b_two = value[15:0];
            REG_STABILIZER: eps   = value[23:0];
            default:        lrate = value[23:0];
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 255) - 128;
            3:       return 32'(signed'($urandom_range(0, 33554432)) - 16777216);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        send_update(12'd0, 32'h0, 32'h0, 1'b0, 0);          // no step taken yet
        send_update(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0);
        send_update(12'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0);
        send_update(12'd1, 32'h0100_0000, 32'hFF00_0000, 1'b0, 0);
        send_update(12'd2, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 0);
        send_update(12'd4095, 32'h0, 32'h7FFF_FFFF, 1'b0, 0);
        send_update(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0);
        send_update(12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 0);
        drain();
    endtask

    task automatic test_zero_denominator();
        // stabilizer zero and zero second moment: root + eps is zero
        write_reg(REG_STABILIZER, 32'd0);
        send_update(12'd100, 32'h0100_0000, 32'h0, 1'b0, 0);
        send_update(12'd101, 32'h0100_0000, 32'h0, 1'b1, 0);
        drain();
    endtask

    task automatic test_random_phase(int count, logic [15:0] bo, logic [15:0] bt,
                                     logic [23:0] ep, logic [23:0] lr);
        logic [11:0] idx;
        write_reg(REG_BETA_ONE, bo);
        write_reg(REG_BETA_TWO, bt);
        write_reg(REG_STABILIZER, ep);
        write_reg(REG_STEP_RATE, lr);
        stall_enable = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            // tight index range so moments accumulate and repeats go back to back
            idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
            send_update(idx, rand_word(), rand_word(), $urandom_range(0, 15) == 0, 1);
        end
        stall_enable = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        // hold the receiver while requests keep coming until the input stalls
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 200; i++)
                send_update(12'($urandom_range(0, 7)), rand_word(), rand_word(),
                            i % 50 == 0, 0);
        join
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        element_index = '0;
        weight_in     = '0;
        gradient      = '0;
        tensor_start  = 1'b0;
        out_ready     = 1'b1;
        hold_off      = 1'b0;
        stall_enable  = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        for (int i = 0; i < MOMENT_DEPTH; i++)
        begin
            mom_one[i] = '0;
            mom_two[i] = '0;
        end
        pow_one = ONE_Q24;
        pow_two = ONE_Q24;
        b_one   = BETA_ONE_RST;
        b_two   = BETA_TWO_RST;
        eps     = STABILIZER_RST;
        lrate   = STEP_RATE_RST;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_zero_denominator();
        test_random_phase(500, BETA_ONE_RST, BETA_TWO_RST, STABILIZER_RST, STEP_RATE_RST);
        test_backpressure();
        test_random_phase(350, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        test_random_phase(350, 16'h0000, 16'h0000, 24'd0, 24'd0);
        test_random_phase(350, 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));

        if (fail_count == 0)
            $display("adam_optimizer_update verification clean");
        else
            $display("adam_optimizer_update verification failed");
        $finish;
    end

endmodule
